[sv/assert_macros.svh]
// Assertion macros shared by the fan duty controller RTL.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/fdh_pkg.sv]
// Types and constants of the fan duty controller.
// No dependencies; used by every module of the block.
package fdh_pkg;

  localparam int TEMP_W = 19;
  localparam int SPAN_W = 17;
  localparam int PCT_W  = 7;
  localparam int PER_W  = 20;
  localparam int EXC_W  = TEMP_W + 1;
  localparam int PROD_W = SPAN_W + PER_W;
  localparam int CMP_W  = SPAN_W + PCT_W;
  localparam int CNT_W  = 6;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [PER_W-1:0]         DUTY_MAX     = 20'hFFFFF;
  localparam logic [SPAN_W-1:0]        FLOOR_DIV    = 17'd100;
  localparam logic signed [TEMP_W-1:0] RST_STOP_THR = 19'sd35000;
  localparam logic signed [TEMP_W-1:0] RST_GO_THR   = 19'sd40000;
  localparam logic [SPAN_W-1:0]        RST_SPAN     = 17'd25000;
  localparam logic [PCT_W-1:0]         RST_MIN_PCT  = 7'd50;
  localparam logic [PER_W-1:0]         RST_PERIOD   = 20'd40000;

  typedef enum logic [2:0] {
    REG_STOP_THR = 3'd0,
    REG_GO_THR   = 3'd1,
    REG_SPAN     = 3'd2,
    REG_MIN_PCT  = 3'd3,
    REG_PERIOD   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_CMP,
    MODE_FLOOR,
    MODE_RATIO
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] stop_thr;
    logic signed [TEMP_W-1:0] go_thr;
    logic [SPAN_W-1:0]        span;
    logic [PCT_W-1:0]         min_pct;
    logic [PER_W-1:0]         period;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] a;
    logic [PER_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quo;
  } div_rsp_t;

endpackage

[sv/fdh_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on fdh_pkg for the register map and reset values.
module fdh_regs import fdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_thr <= RST_STOP_THR;
      cfg.go_thr   <= RST_GO_THR;
      cfg.span     <= RST_SPAN;
      cfg.min_pct  <= RST_MIN_PCT;
      cfg.period   <= RST_PERIOD;
    end else if (wr_en) begin
      unique case (idx)
        REG_STOP_THR: cfg.stop_thr <= pwdata[TEMP_W-1:0];
        REG_GO_THR:   cfg.go_thr   <= pwdata[TEMP_W-1:0];
        REG_SPAN:     cfg.span     <= pwdata[SPAN_W-1:0];
        REG_MIN_PCT:  cfg.min_pct  <= pwdata[PCT_W-1:0];
        REG_PERIOD:   cfg.period   <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STOP_THR: prdata = {{(DATA_W-TEMP_W){cfg.stop_thr[TEMP_W-1]}}, cfg.stop_thr};
      REG_GO_THR:   prdata = {{(DATA_W-TEMP_W){cfg.go_thr[TEMP_W-1]}}, cfg.go_thr};
      REG_SPAN:     prdata = DATA_W'(cfg.span);
      REG_MIN_PCT:  prdata = DATA_W'(cfg.min_pct);
      REG_PERIOD:   prdata = DATA_W'(cfg.period);
      default:      prdata = '0;
    endcase
  end

endmodule

[sv/fdh_serial_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, stops when the multiplier empties.
// Depends on fdh_pkg for the request and response types.
module fdh_serial_mul import fdh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [PROD_W-1:0] mcand;
  logic [PER_W-1:0]  mplier;
  logic [PROD_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && mplier == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mcand  <= req.a;
      mplier <= req.b;
    end else if (busy && mplier != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[PER_W-1:1]};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

[sv/fdh_serial_div.sv]
// Restoring divider, one quotient bit per cycle over the full dividend width.
// Depends on fdh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fdh_serial_div import fdh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] quo;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] den;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              fits;

  assign trial = {rem, quo[PROD_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= fits ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

  `ASSERT_ALWAYS(a_rem_below_den, clk, rst, !busy || rem < den)
  `ASSERT_ALWAYS(a_no_restart, clk, rst, !(req.start && busy))
  `ASSERT_NEXT(a_start_runs, clk, rst, req.start, busy)

endmodule

[sv/fan_duty_hysteresis_controller.sv]
// Fan duty controller: hysteresis flag and linear PWM high time per temperature word.
// Path to the output handshake: straight to ST_DONE when not cooling, via ST_CLASS above
// the span, otherwise through the shift-add multiplier (one multiplier bit per cycle) and the
// restoring divider. One word at a time; the next word is taken once the previous result
// sits in the output register.
// Synchronous reset restores the register defaults, clears cooling and the held duty.
`include "assert_macros.svh"
module fan_duty_hysteresis_controller import fdh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TEMP_W-1:0] temp_milli,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     fan_on,
  output logic [PER_W-1:0]         duty_ns,
  output logic                     duty_written
);

  cfg_t     cfg;
  state_t   state;
  state_t   state_next;
  mode_t    mode;
  mode_t    mode_next;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    cooling;
  logic [PER_W-1:0]        held_duty;
  logic [PER_W-1:0]        duty_res;
  logic signed [EXC_W-1:0] excess;
  logic signed [EXC_W-1:0] excess_calc;
  logic [CMP_W-1:0]        excess100;
  logic [SPAN_W-1:0]       ex_low;
  logic                    cool_new;
  logic                    above_span;
  logic                    floor_now;
  logic                    below_floor;
  logic                    out_load;

  fdh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdh_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  fdh_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign excess_calc = {temp_milli[TEMP_W-1], temp_milli} -
                       {cfg.stop_thr[TEMP_W-1], cfg.stop_thr};
  assign cool_new    = cooling ? !(temp_milli < cfg.stop_thr) : (temp_milli > cfg.go_thr);
  assign above_span  = excess > $signed({{(EXC_W-SPAN_W){1'b0}}, cfg.span});
  assign floor_now   = excess[EXC_W-1] || cfg.span == '0;
  assign ex_low      = excess[SPAN_W-1:0];
  assign below_floor = excess100 < mul_rsp.prod[CMP_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = cool_new ? ST_CLASS : ST_DONE;
      ST_CLASS: state_next = above_span ? ST_DONE : ST_MUL;
      ST_MUL:   if (mul_rsp.done && mode != MODE_CMP) state_next = ST_DIV;
      ST_DIV:   if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mode_next = mode;
    mul_req   = '0;
    div_req   = '0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_CLASS: begin
        if (!above_span) begin
          mul_req.start = 1'b1;
          mul_req.b     = PER_W'(cfg.min_pct);
          if (floor_now) begin
            mul_req.a = PROD_W'(cfg.period);
            mode_next = MODE_FLOOR;
          end else begin
            mul_req.a = PROD_W'(cfg.span);
            mode_next = MODE_CMP;
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          unique case (mode)
            MODE_CMP: begin
              mul_req.start = 1'b1;
              if (below_floor) begin
                mul_req.a = PROD_W'(cfg.period);
                mul_req.b = PER_W'(cfg.min_pct);
                mode_next = MODE_FLOOR;
              end else begin
                mul_req.a = PROD_W'(ex_low);
                mul_req.b = cfg.period;
                mode_next = MODE_RATIO;
              end
            end
            MODE_FLOOR: begin
              div_req.start = 1'b1;
              div_req.num   = mul_rsp.prod;
              div_req.den   = FLOOR_DIV;
            end
            MODE_RATIO: begin
              div_req.start = 1'b1;
              div_req.num   = mul_rsp.prod;
              div_req.den   = cfg.span;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: ;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_CMP;
      cooling   <= 1'b0;
      held_duty <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (in_valid && in_ready) begin
        cooling <= cool_new;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        if (cooling) begin
          held_duty <= duty_res;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      excess <= excess_calc;
    end
    if (state == ST_CLASS) begin
      excess100 <= CMP_W'({ex_low, 6'b0}) + CMP_W'({ex_low, 5'b0}) + CMP_W'({ex_low, 2'b0});
      if (above_span) begin
        duty_res <= cfg.period;
      end
    end
    if (div_rsp.done) begin
      duty_res <= (div_rsp.quo[PROD_W-1:PER_W] != '0) ? DUTY_MAX : div_rsp.quo[PER_W-1:0];
    end
    if (out_load) begin
      fan_on       <= cooling;
      duty_written <= cooling;
      duty_ns      <= cooling ? duty_res : held_duty;
    end
  end

  `ASSERT_ALWAYS(a_written_tracks_fan, clk, rst, !out_valid || duty_written == fan_on)
  `ASSERT_ALWAYS(a_one_unit_busy, clk, rst, !(mul_rsp.busy && div_rsp.busy))
  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != ST_IDLE)

endmodule
